// ===== hdl/ucbt_pkg.sv =====
// ============================================================================
// ucbt_pkg: shared types, constants and functions of the CJK bigram tokenizer
// Payload structs for both channels, the queue entry that passes from the
// decode front to the token back, and the UTF-8 and character class helpers.
// ============================================================================
`default_nettype none

package ucbt_pkg;

	// Code point width after a four-byte sequence
	localparam int CP_W = 21;
	// Code points carried by one queue entry (a cut sequence at text end)
	localparam int QPTS = 3;
	// Held bytes of a pending sequence
	localparam int PEND_DEPTH = 3;
	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Result kinds
	localparam logic [2:0] KIND_WORD_CHAR = 3'd0;
	localparam logic [2:0] KIND_WORD_END  = 3'd1;
	localparam logic [2:0] KIND_UNIGRAM   = 3'd2;
	localparam logic [2:0] KIND_BIGRAM    = 3'd3;
	localparam logic [2:0] KIND_TEXT_END  = 3'd4;

	// Lead byte patterns
	localparam logic [7:0] LEAD2_MASK = 8'he0;
	localparam logic [7:0] LEAD2_CODE = 8'hc0;
	localparam logic [7:0] LEAD3_MASK = 8'hf0;
	localparam logic [7:0] LEAD3_CODE = 8'he0;
	localparam logic [7:0] LEAD4_MASK = 8'hf8;
	localparam logic [7:0] LEAD4_CODE = 8'hf0;

	// CJK ranges: kana, ext A, unified, compatibility, hangul
	localparam logic [CP_W-1:0] KANA_LO   = 21'h3040;
	localparam logic [CP_W-1:0] KANA_HI   = 21'h30ff;
	localparam logic [CP_W-1:0] EXTA_LO   = 21'h3400;
	localparam logic [CP_W-1:0] EXTA_HI   = 21'h4dbf;
	localparam logic [CP_W-1:0] UNIF_LO   = 21'h4e00;
	localparam logic [CP_W-1:0] UNIF_HI   = 21'h9fff;
	localparam logic [CP_W-1:0] COMPAT_LO = 21'hf900;
	localparam logic [CP_W-1:0] COMPAT_HI = 21'hfaff;
	localparam logic [CP_W-1:0] HANGUL_LO = 21'hac00;
	localparam logic [CP_W-1:0] HANGUL_HI = 21'hd7af;

	// ASCII word characters
	localparam logic [CP_W-1:0] ASC_LOW_A = 21'h61;
	localparam logic [CP_W-1:0] ASC_LOW_Z = 21'h7a;
	localparam logic [CP_W-1:0] ASC_UP_A  = 21'h41;
	localparam logic [CP_W-1:0] ASC_UP_Z  = 21'h5a;
	localparam logic [CP_W-1:0] ASC_ZERO  = 21'h30;
	localparam logic [CP_W-1:0] ASC_NINE  = 21'h39;
	localparam logic [CP_W-1:0] ASC_UNDER = 21'h5f;
	localparam logic [CP_W-1:0] ASC_MINUS = 21'h2d;
	localparam logic [CP_W-1:0] ASC_PLUS  = 21'h2b;
	localparam logic [15:0]     CASE_STEP = 16'd32;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [15:0] symbol;
		logic [15:0] bigram_first;
		logic        final_result;
	} out_item_t;

	typedef enum logic [1:0] {
		PCLS_OTHER,
		PCLS_WORD,
		PCLS_CJK
	} pcls_t;

	// One classified code point; sym is lowercased for word characters
	typedef struct packed {
		pcls_t       cls;
		logic [15:0] sym;
	} point_t;

	typedef struct packed {
		point_t [QPTS-1:0] pts;
		logic [1:0]        npts;
		logic              eot;
	} entry_t;

	// Continuation bytes that a lead byte calls for
	function automatic logic [1:0] follow_count(input logic [7:0] b);
		priority if ((b & LEAD2_MASK) == LEAD2_CODE) return 2'd1;
		else if ((b & LEAD3_MASK) == LEAD3_CODE) return 2'd2;
		else if ((b & LEAD4_MASK) == LEAD4_CODE) return 2'd3;
		else return 2'd0;
	endfunction

	// Join a lead byte and k continuation bytes
	function automatic logic [CP_W-1:0] assemble(input logic [7:0] s0, input logic [7:0] s1,
			input logic [7:0] s2, input logic [7:0] s3, input logic [1:0] k);
		unique case (k)
			2'd1: return {10'd0, s0[4:0], s1[5:0]};
			2'd2: return {5'd0, s0[3:0], s1[5:0], s2[5:0]};
			default: return {s0[2:0], s1[5:0], s2[5:0], s3[5:0]};
		endcase
	endfunction

	// Sort a code point into word, CJK or other
	function automatic point_t classify(input logic [CP_W-1:0] cp);
		point_t p;
		p.sym = cp[15:0];
		p.cls = PCLS_OTHER;
		if ((cp >= ASC_LOW_A && cp <= ASC_LOW_Z) || (cp >= ASC_ZERO && cp <= ASC_NINE) ||
				cp == ASC_UNDER || cp == ASC_MINUS || cp == ASC_PLUS) begin
			p.cls = PCLS_WORD;
		end else if (cp >= ASC_UP_A && cp <= ASC_UP_Z) begin
			p.cls = PCLS_WORD;
			p.sym = cp[15:0] + CASE_STEP;
		end else if ((cp >= KANA_LO && cp <= KANA_HI) || (cp >= EXTA_LO && cp <= EXTA_HI) ||
				(cp >= UNIF_LO && cp <= UNIF_HI) || (cp >= COMPAT_LO && cp <= COMPAT_HI) ||
				(cp >= HANGUL_LO && cp <= HANGUL_HI)) begin
			p.cls = PCLS_CJK;
		end
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/utf8_cjk_bigram_tokenizer.sv =====
// ============================================================================
// utf8_cjk_bigram_tokenizer: UTF-8 decode with word and CJK bigram tokens
// Decodes a byte stream leniently, emits lowercased word characters, word
// ends, CJK unigrams and bigrams, and a text end beat per text.
// ============================================================================
//
// Channel  Handshake                 Payload      Beat
// -------  ------------------------  -----------  ---------------------------
// byte     byte_valid / byte_ready   byte_item    one text byte, end flag
// token    token_valid / token_ready token_item   one result, final flag
//
// A byte is taken every cycle while the entry queue (QueueDepth deep) has room.
// The back end gives one result beat per cycle while the token channel does not
// stall: a CJK point after a CJK point gives a bigram and then its unigram, one
// after a word a word end and then its unigram; a text end closes an open word.
// A taken byte's first result passes through the queue slot and then the output
// register; a point that gives no result still takes a step of the back end.
// Reset clears the sequence, word and CJK state and empties the queue.
// A stalled token beat holds the output register; the queue keeps filling.
// ============================================================================
`default_nettype none

module utf8_cjk_bigram_tokenizer #(
	parameter int QueueDepth = ucbt_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  ucbt_pkg::in_item_t  byte_item,
	output logic                token_valid,
	input  logic                token_ready,
	output ucbt_pkg::out_item_t token_item
);
	import ucbt_pkg::*;

	logic   take;
	logic   q_push;
	logic   q_full;
	logic   q_pop;
	logic   q_head_valid;
	entry_t q_wr_entry;
	entry_t q_head;

	assign byte_ready = !q_full;
	assign take       = byte_valid && byte_ready;

	ucbt_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (byte_item),
		.push   (q_push),
		.entry  (q_wr_entry)
	);

	ucbt_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.wr_entry   (q_wr_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	ucbt_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (q_head_valid),
		.head        (q_head),
		.pop         (q_pop),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token_item  (token_item)
	);

`ifndef ASSERT_OFF
	// A taken bigram is followed at once by the unigram of its second point
	a_bigram_then_unigram: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_ready && token_item.event_kind == KIND_BIGRAM
		|=> token_valid && token_item.event_kind == KIND_UNIGRAM &&
			token_item.symbol == $past(token_item.symbol))
		else $error("bigram beat not followed by its unigram");

	// Text end closes the results of its byte and carries no symbols
	a_text_end_final: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_item.event_kind == KIND_TEXT_END
		|-> token_item.final_result && token_item.symbol == '0 &&
			token_item.bigram_first == '0)
		else $error("text end beat malformed");

	// The front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("entry pushed into full queue");
`endif

endmodule

`default_nettype wire

// ===== hdl/ucbt_decode.sv =====
// ============================================================================
// ucbt_decode: UTF-8 decode front
// Gathers lead and continuation bytes, decodes finished sequences, flushes a
// cut sequence at text end and classifies up to three code points per beat.
// ============================================================================
`default_nettype none

module ucbt_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  ucbt_pkg::in_item_t item,
	output logic               push,
	output ucbt_pkg::entry_t   entry
);
	import ucbt_pkg::*;

	logic [PEND_DEPTH-1:0][7:0] pend_q;
	logic [PEND_DEPTH-1:0][7:0] pend_n;
	logic [1:0]                 cnt_q;
	logic [1:0]                 cnt_n;
	logic [1:0]                 need_q;
	logic [1:0]                 need_n;
	logic [7:0]                 in_byte;
	logic [1:0]                 k_in;
	logic                       main_hit;
	logic [CP_W-1:0]            main_cp;
	logic [CP_W-1:0]            cp0;
	logic [CP_W-1:0]            cp1;
	logic [CP_W-1:0]            cp2;
	logic [1:0]                 npts;

	assign in_byte = item.text_byte;
	assign k_in    = follow_count(in_byte);

	// Hold a lead byte, gather continuation bytes, or decode one code point
	always_comb begin
		pend_n   = pend_q;
		cnt_n    = cnt_q;
		need_n   = need_q;
		main_hit = 1'b0;
		main_cp  = '0;
		if (cnt_q == 2'd0) begin
			if (k_in == 2'd0) begin
				main_hit = 1'b1;
				main_cp  = {13'd0, in_byte};
			end else begin
				pend_n[0] = in_byte;
				cnt_n     = 2'd1;
				need_n    = k_in;
			end
		end else if (cnt_q >= need_q || cnt_q > 2'd2) begin
			main_hit = 1'b1;
			main_cp  = assemble(pend_q[0], (need_q == 2'd1) ? in_byte : pend_q[1],
				(need_q == 2'd2) ? in_byte : pend_q[2], in_byte, need_q);
			cnt_n    = 2'd0;
			need_n   = 2'd0;
		end else begin
			pend_n[cnt_q] = in_byte;
			cnt_n         = cnt_q + 2'd1;
		end
	end

	// At text end, decode the held bytes again with only the room left
	always_comb begin
		cp0  = main_cp;
		cp1  = '0;
		cp2  = '0;
		npts = {1'b0, main_hit};
		if (item.end_of_text && cnt_n != 2'd0) begin
			cp0  = {13'd0, pend_n[0]};
			cp1  = {13'd0, pend_n[1]};
			cp2  = {13'd0, pend_n[2]};
			npts = cnt_n;
			if (cnt_n == 2'd3 && follow_count(pend_n[1]) == 2'd1) begin
				cp1  = assemble(pend_n[1], pend_n[2], 8'd0, 8'd0, 2'd1);
				npts = 2'd2;
			end
		end
	end

	// Classify and pack the queue entry
	always_comb begin
		entry.pts[0] = classify(cp0);
		entry.pts[1] = classify(cp1);
		entry.pts[2] = classify(cp2);
		entry.npts   = npts;
		entry.eot    = item.end_of_text;
	end

	// Drop beats that only park a byte
	assign push = take && (npts != 2'd0 || item.end_of_text);

	// Sequence progress; clear it at text end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			need_q <= 2'd0;
		end else if (take) begin
			cnt_q  <= item.end_of_text ? 2'd0 : cnt_n;
			need_q <= item.end_of_text ? 2'd0 : need_n;
		end
	end

	// Held bytes
	always_ff @(posedge clk) begin
		if (take) begin
			pend_q <= pend_n;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ucbt_queue.sv =====
// ============================================================================
// ucbt_queue: entry queue between decode front and token back
// Small register FIFO; lets the front keep taking bytes while the back
// works through a burst of results.
// ============================================================================
`default_nettype none

module ucbt_queue #(
	parameter int Depth = ucbt_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ucbt_pkg::entry_t wr_entry,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output ucbt_pkg::entry_t head
);
	import ucbt_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	entry_t          slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full       = (count_q == CntW'(Depth));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];

	// Write the slot at the tail
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ucbt_emit.sv =====
// ============================================================================
// ucbt_emit: token back end
// Walks the head entry's code points, one result beat per cycle unless stalled,
// tracks the open word and prior CJK point, and drives the output register.
// ============================================================================
`default_nettype none

module ucbt_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  ucbt_pkg::entry_t    head,
	output logic                pop,
	output logic                token_valid,
	input  logic                token_ready,
	output ucbt_pkg::out_item_t token_item
);
	import ucbt_pkg::*;

	logic [1:0]  pidx_q;
	logic [1:0]  pidx_inc;
	logic        word_open_q;
	logic        prior_cjk_q;
	logic [15:0] prior_pt_q;
	logic        tok_valid_q;
	out_item_t   tok_item_q;

	point_t      cur;
	logic        at_end;
	logic        rem_live;
	logic        rem_any;
	logic        last_pt;
	logic        slot_free;
	logic        fire;
	logic        emit;
	logic        adv;
	logic        wo_n;
	logic        pc_n;
	logic [15:0] pp_n;
	out_item_t   res;

	assign pidx_inc  = pidx_q + 2'd1;
	assign at_end    = (pidx_q == head.npts);
	assign last_pt   = ({1'b0, pidx_q} + 3'd1 == {1'b0, head.npts});
	assign rem_any   = ({1'b0, pidx_q} + 3'd1 < {1'b0, head.npts});
	assign slot_free = !tok_valid_q || token_ready;

	// Select the current code point
	always_comb begin
		unique case (pidx_q)
			2'd0: cur = head.pts[0];
			2'd1: cur = head.pts[1];
			default: cur = head.pts[2];
		endcase
	end

	// Look ahead: does a later point of this entry always give a result
	always_comb begin
		rem_live = 1'b0;
		for (int j = 0; j < QPTS; j++) begin
			if (2'(j) > pidx_q && 2'(j) < head.npts && head.pts[j].cls != PCLS_OTHER) begin
				rem_live = 1'b1;
			end
		end
	end

	// Pick this cycle's step and the state it leaves
	always_comb begin
		emit             = 1'b0;
		adv              = 1'b0;
		wo_n             = word_open_q;
		pc_n             = prior_cjk_q;
		pp_n             = prior_pt_q;
		res.event_kind   = KIND_WORD_END;
		res.symbol       = '0;
		res.bigram_first = '0;
		res.final_result = 1'b0;
		if (!at_end) begin
			unique case (cur.cls)
				PCLS_WORD: begin
					emit           = 1'b1;
					res.event_kind = KIND_WORD_CHAR;
					res.symbol     = cur.sym;
					wo_n           = 1'b1;
					pc_n           = 1'b0;
					adv            = 1'b1;
				end
				PCLS_CJK: begin
					emit = 1'b1;
					if (word_open_q) begin
						res.event_kind = KIND_WORD_END;
						wo_n           = 1'b0;
					end else if (prior_cjk_q) begin
						res.event_kind   = KIND_BIGRAM;
						res.symbol       = cur.sym;
						res.bigram_first = prior_pt_q;
						pc_n             = 1'b0;
					end else begin
						res.event_kind = KIND_UNIGRAM;
						res.symbol     = cur.sym;
						pc_n           = 1'b1;
						pp_n           = cur.sym;
						adv            = 1'b1;
					end
				end
				default: begin
					emit = word_open_q;
					wo_n = 1'b0;
					pc_n = 1'b0;
					adv  = 1'b1;
				end
			endcase
			res.final_result = adv && !head.eot && !rem_live &&
				!(cur.cls == PCLS_WORD && rem_any);
		end else begin
			emit = 1'b1;
			if (word_open_q) begin
				res.event_kind = KIND_WORD_END;
				wo_n           = 1'b0;
			end else begin
				res.event_kind   = KIND_TEXT_END;
				res.final_result = 1'b1;
				pc_n             = 1'b0;
				pp_n             = '0;
			end
		end
	end

	// Take the step when the entry is there and the result, if any, has room
	assign fire = head_valid && (!emit || slot_free);
	assign pop  = fire && ((adv && last_pt && !head.eot) ||
		(at_end && !word_open_q));

	// Advance the point cursor and the word and CJK state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pidx_q      <= 2'd0;
			word_open_q <= 1'b0;
			prior_cjk_q <= 1'b0;
			prior_pt_q  <= '0;
		end else if (fire) begin
			word_open_q <= wo_n;
			prior_cjk_q <= pc_n;
			prior_pt_q  <= pp_n;
			if (pop) begin
				pidx_q <= 2'd0;
			end else if (adv) begin
				pidx_q <= pidx_inc;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (fire && emit) begin
			tok_valid_q <= 1'b1;
		end else if (token_ready) begin
			tok_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (fire && emit) begin
			tok_item_q <= res;
		end
	end

	assign token_valid = tok_valid_q;
	assign token_item  = tok_item_q;

endmodule

`default_nettype wire
